FILE: sv/pli_pkg.sv
// shared types for the piecewise linear interpolator
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

  // control bits that travel with every beat down the pipeline
  typedef struct packed {
    logic valid;    // stage holds a beat
    logic query;    // 1 = query beat, 0 = knot load beat
    logic slot_ok;  // load slot lies inside the table
  } pli_ctl_t;

  // pipeline depth outside the search and divide sections
  localparam int unsigned PLI_FIXED_STAGES = 6;

endpackage

`default_nettype wire

FILE: sv/piecewise_linear_interpolator_unit.sv
// top level of the piecewise linear interpolator
//
//  channel  dir  handshake            payload
//  in       in   in_valid / in_stall  kind, entry_index, knot_x, knot_y, query_x
//  out      out  out_valid/ out_stall value
//  cfg      in   cfg_wr_en            cfg_wr_data (knots in use)
//
// one beat enters per cycle while in_stall is low; a query result is
// offered after the entry register, the search steps (each with a probe
// read register and a window register), the fetch, clamp and multiply
// registers, the divider's entry and quotient bit stages and the output register
// rst is synchronous and clears all valid bits and the knot count
// a stalled result freezes the whole pipeline and in_stall follows it
// knot loads travel the pipeline so each table copy sees them in order
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator_unit
  import pli_pkg::*;
#(
  parameter int MAX_KNOTS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          kind,
  input  wire logic [5:0]                    entry_index,
  input  wire logic signed [DATA_WIDTH-1:0]  knot_x,
  input  wire logic signed [DATA_WIDTH-1:0]  knot_y,
  input  wire logic signed [DATA_WIDTH-1:0]  query_x,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]       value,
  input  wire logic                          cfg_wr_en,
  input  wire logic [6:0]                    cfg_wr_data
);

  localparam int AW    = $clog2(MAX_KNOTS);
  localparam int NW    = $clog2(MAX_KNOTS + 1);
  localparam int STEPS = NW;           // window halves until empty
  localparam int CW    = (NW > 7) ? NW : 7;
  localparam int XW    = ((AW > 6) ? AW : 6) + 1;  // one spare bit for the range check
  localparam int HL    = DATA_WIDTH / 2;
  localparam int HH    = DATA_WIDTH - HL;
  localparam int SW    = 2 * DATA_WIDTH + 2;

  // whole pipeline advances unless the output holds an unaccepted result
  logic en;
  logic in_fire;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign in_fire  = in_valid && !in_stall;

  // knot count, clamped to the table size when written
  logic [NW-1:0] knots;
  logic [CW-1:0] cfg_ext;

  assign cfg_ext = CW'(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      knots <= '0;
    end else if (cfg_wr_en) begin
      knots <= (cfg_ext > CW'(MAX_KNOTS)) ? NW'(MAX_KNOTS) : cfg_ext[NW-1:0];
    end
  end

  // entry register
  logic [XW-1:0] slot_ext;

  assign slot_ext = XW'(entry_index);

  pli_ctl_t                     s_ctl   [STEPS+1];
  logic signed [DATA_WIDTH-1:0] s_x     [STEPS+1];
  logic signed [DATA_WIDTH-1:0] s_y     [STEPS+1];
  logic [AW-1:0]                s_slot  [STEPS+1];
  logic [NW-1:0]                s_first [STEPS+1];
  logic [NW-1:0]                s_count [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      s_x[0]     <= kind ? query_x : knot_x;
      s_y[0]     <= knot_y;
      s_slot[0]  <= slot_ext[AW-1:0];
      s_first[0] <= '0;
      s_count[0] <= knots;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_ctl[0] <= '0;
    end else if (en) begin
      s_ctl[0].valid   <= in_fire;
      s_ctl[0].query   <= kind;
      s_ctl[0].slot_ok <= slot_ext < XW'(MAX_KNOTS);
    end
  end

  // binary search, one table copy per step
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    pli_search_step #(
      .MAX_KNOTS  (MAX_KNOTS),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_ctl    (s_ctl[k]),
      .in_x      (s_x[k]),
      .in_y      (s_y[k]),
      .in_slot   (s_slot[k]),
      .in_first  (s_first[k]),
      .in_count  (s_count[k]),
      .out_ctl   (s_ctl[k+1]),
      .out_x     (s_x[k+1]),
      .out_y     (s_y[k+1]),
      .out_slot  (s_slot[k+1]),
      .out_first (s_first[k+1]),
      .out_count (s_count[k+1])
    );
  end

  // segment and last-knot reads
  pli_ctl_t                     f_ctl;
  logic signed [DATA_WIDTH-1:0] f_x;
  logic signed [DATA_WIDTH-1:0] f_y;
  logic [AW-1:0]                f_slot;
  logic signed [DATA_WIDTH-1:0] f_xl;
  logic signed [DATA_WIDTH-1:0] f_xr;
  logic signed [DATA_WIDTH-1:0] f_yl;
  logic signed [DATA_WIDTH-1:0] f_yr;
  logic signed [DATA_WIDTH-1:0] e_x;
  logic signed [DATA_WIDTH-1:0] e_y;

  pli_seg_fetch #(
    .MAX_KNOTS  (MAX_KNOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_fetch (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .knots    (knots),
    .in_ctl   (s_ctl[STEPS]),
    .in_x     (s_x[STEPS]),
    .in_y     (s_y[STEPS]),
    .in_slot  (s_slot[STEPS]),
    .in_first (s_first[STEPS]),
    .out_ctl  (f_ctl),
    .out_x    (f_x),
    .out_y    (f_y),
    .out_slot (f_slot),
    .out_xl   (f_xl),
    .out_xr   (f_xr),
    .out_yl   (f_yl),
    .out_yr   (f_yr)
  );

  pli_end_read #(
    .MAX_KNOTS  (MAX_KNOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_end (
    .clk     (clk),
    .en      (en),
    .knots   (knots),
    .in_ctl  (s_ctl[STEPS]),
    .in_x    (s_x[STEPS]),
    .in_y    (s_y[STEPS]),
    .in_slot (s_slot[STEPS]),
    .end_x   (e_x),
    .end_y   (e_y)
  );

  // first knot kept in registers, updated as loads reach this point
  logic signed [DATA_WIDTH-1:0] first_x;
  logic signed [DATA_WIDTH-1:0] first_y;

  always_ff @(posedge clk) begin
    if (en && f_ctl.valid && !f_ctl.query && f_ctl.slot_ok && f_slot == '0) begin
      first_x <= f_x;
      first_y <= f_y;
    end
  end

  // clamp decisions and multiply operands
  logic signed [DATA_WIDTH:0]   seg_w;
  logic signed [DATA_WIDTH:0]   dx;
  logic signed [DATA_WIDTH:0]   dy;
  logic                         direct;
  logic signed [DATA_WIDTH-1:0] direct_val;

  assign seg_w = {f_xr[DATA_WIDTH-1], f_xr} - {f_xl[DATA_WIDTH-1], f_xl};
  assign dx    = {f_x[DATA_WIDTH-1], f_x} - {f_xl[DATA_WIDTH-1], f_xl};
  assign dy    = {f_yr[DATA_WIDTH-1], f_yr} - {f_yl[DATA_WIDTH-1], f_yl};

  always_comb begin
    direct     = 1'b1;
    direct_val = f_yl;
    if (knots == '0) begin
      direct_val = '0;
    end else if (knots == NW'(1) || f_x <= first_x) begin
      direct_val = first_y;
    end else if (f_x >= e_x) begin
      direct_val = e_y;
    end else if (seg_w <= 0) begin
      direct_val = f_yl;
    end else begin
      direct = 1'b0;
    end
  end

  logic                         c_valid;
  logic                         c_direct;
  logic signed [DATA_WIDTH-1:0] c_dval;
  logic signed [DATA_WIDTH-1:0] c_yl;
  logic                         c_neg;
  logic [DATA_WIDTH-1:0]        c_a;
  logic [DATA_WIDTH-1:0]        c_d;
  logic [DATA_WIDTH-1:0]        c_w;

  always_ff @(posedge clk) begin
    if (en) begin
      c_direct <= direct;
      c_dval   <= direct_val;
      c_yl     <= f_yl;
      c_neg    <= dy < 0;
      c_a      <= (dx < 0) ? '0 : dx[DATA_WIDTH-1:0];
      c_d      <= (dy < 0) ? DATA_WIDTH'(-dy) : dy[DATA_WIDTH-1:0];
      c_w      <= seg_w[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= f_ctl.valid && f_ctl.query;
    end
  end

  // product in two halves, then summed
  logic                        m1_valid;
  logic [DATA_WIDTH+HL-1:0]    m1_lo;
  logic [DATA_WIDTH+HH-1:0]    m1_hi;
  logic [DATA_WIDTH-1:0]       m1_w;
  logic [SW-1:0]               m1_side;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_lo   <= (DATA_WIDTH+HL)'(c_a) * (DATA_WIDTH+HL)'(c_d[HL-1:0]);
      m1_hi   <= (DATA_WIDTH+HH)'(c_a) * (DATA_WIDTH+HH)'(c_d[DATA_WIDTH-1:HL]);
      m1_w    <= c_w;
      m1_side <= {c_direct, c_dval, c_yl, c_neg};
    end
  end

  logic                        m2_valid;
  logic [2*DATA_WIDTH-1:0]     m2_p;
  logic [DATA_WIDTH-1:0]       m2_w;
  logic [SW-1:0]               m2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_p    <= (2*DATA_WIDTH)'(m1_lo) + ((2*DATA_WIDTH)'(m1_hi) << HL);
      m2_w    <= m1_w;
      m2_side <= m1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= c_valid;
      m2_valid <= m1_valid;
    end
  end

  // quotient (x - xl) * |dy| / w
  logic                  dv_valid;
  logic [DATA_WIDTH:0]   dv_quo;
  logic                  dv_sat;
  logic [SW-1:0]         dv_side;

  pli_divider #(
    .DATA_WIDTH (DATA_WIDTH),
    .SIDE_WIDTH (SW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_valid),
    .in_num    (m2_p),
    .in_den    (m2_w),
    .in_side   (m2_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_sat   (dv_sat),
    .out_side  (dv_side)
  );

  // apply the step to the left ordinate and saturate
  // quotient can reach 2^(DATA_WIDTH+1) - 1 with out-of-order abscissae
  logic                         o_direct;
  logic signed [DATA_WIDTH-1:0] o_dval;
  logic signed [DATA_WIDTH-1:0] o_yl;
  logic                         o_neg;
  logic signed [DATA_WIDTH+2:0] o_yl_ext;
  logic signed [DATA_WIDTH+2:0] o_q_ext;
  logic signed [DATA_WIDTH+2:0] o_sum;
  logic signed [DATA_WIDTH+2:0] o_max;
  logic signed [DATA_WIDTH+2:0] o_min;
  logic signed [DATA_WIDTH-1:0] value_next;

  assign {o_direct, o_dval, o_yl, o_neg} = dv_side;
  assign o_yl_ext = (DATA_WIDTH+3)'(o_yl);
  assign o_q_ext  = $signed({2'b0, dv_quo});
  assign o_sum    = o_neg ? o_yl_ext - o_q_ext : o_yl_ext + o_q_ext;
  assign o_max    = (DATA_WIDTH+3)'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  assign o_min    = -o_max - (DATA_WIDTH+3)'(1);

  always_comb begin
    if (o_direct) begin
      value_next = o_dval;
    end else if (dv_sat) begin
      value_next = o_neg ? o_min[DATA_WIDTH-1:0] : o_max[DATA_WIDTH-1:0];
    end else if (o_sum > o_max) begin
      value_next = o_max[DATA_WIDTH-1:0];
    end else if (o_sum < o_min) begin
      value_next = o_min[DATA_WIDTH-1:0];
    end else begin
      value_next = o_sum[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pli_search_step.sv
// one step of the pipelined upper-bound search, with its own abscissa copy
`timescale 1ns / 1ps
`default_nettype none

module pli_search_step
  import pli_pkg::*;
#(
  parameter int MAX_KNOTS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    en,
  input  wire pli_ctl_t                                in_ctl,
  input  wire logic signed [DATA_WIDTH-1:0]            in_x,
  input  wire logic signed [DATA_WIDTH-1:0]            in_y,
  input  wire logic [$clog2(MAX_KNOTS)-1:0]            in_slot,
  input  wire logic [$clog2(MAX_KNOTS+1)-1:0]          in_first,
  input  wire logic [$clog2(MAX_KNOTS+1)-1:0]          in_count,
  output pli_ctl_t                                     out_ctl,
  output logic signed [DATA_WIDTH-1:0]                 out_x,
  output logic signed [DATA_WIDTH-1:0]                 out_y,
  output logic [$clog2(MAX_KNOTS)-1:0]                 out_slot,
  output logic [$clog2(MAX_KNOTS+1)-1:0]               out_first,
  output logic [$clog2(MAX_KNOTS+1)-1:0]               out_count
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int NW = $clog2(MAX_KNOTS + 1);

  logic signed [DATA_WIDTH-1:0] mem [MAX_KNOTS];

  logic [NW-1:0] rd_sum;
  logic [AW-1:0] rd_addr;

  pli_ctl_t                     a_ctl;
  logic signed [DATA_WIDTH-1:0] a_x;
  logic signed [DATA_WIDTH-1:0] a_y;
  logic signed [DATA_WIDTH-1:0] a_key;
  logic [AW-1:0]                a_slot;
  logic [NW-1:0]                a_first;
  logic [NW-1:0]                a_count;

  logic [NW-1:0] a_step;
  logic [NW-1:0] first_next;
  logic [NW-1:0] count_next;

  assign rd_sum  = in_first + (in_count >> 1);
  assign rd_addr = rd_sum[AW-1:0];

  // probe read and load write, one beat per cycle while en is high
  always_ff @(posedge clk) begin
    if (en) begin
      a_x     <= in_x;
      a_y     <= in_y;
      a_slot  <= in_slot;
      a_first <= in_first;
      a_count <= in_count;
      a_key   <= mem[rd_addr];
      if (in_ctl.valid && !in_ctl.query && in_ctl.slot_ok) begin
        mem[in_slot] <= in_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (en) begin
      a_ctl <= in_ctl;
    end
  end

  // narrow the window on the probe result
  always_comb begin
    a_step     = a_count >> 1;
    first_next = a_first;
    count_next = a_count;
    if (a_count != '0) begin
      if (!(a_x < a_key)) begin
        first_next = a_first + a_step + NW'(1);
        count_next = a_count - a_step - NW'(1);
      end else begin
        count_next = a_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x     <= a_x;
      out_y     <= a_y;
      out_slot  <= a_slot;
      out_first <= first_next;
      out_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= a_ctl;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pli_seg_fetch.sv
// segment fetch: reads both end knots of the found segment
`timescale 1ns / 1ps
`default_nettype none

module pli_seg_fetch
  import pli_pkg::*;
#(
  parameter int MAX_KNOTS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    en,
  input  wire logic [$clog2(MAX_KNOTS+1)-1:0]          knots,
  input  wire pli_ctl_t                                in_ctl,
  input  wire logic signed [DATA_WIDTH-1:0]            in_x,
  input  wire logic signed [DATA_WIDTH-1:0]            in_y,
  input  wire logic [$clog2(MAX_KNOTS)-1:0]            in_slot,
  input  wire logic [$clog2(MAX_KNOTS+1)-1:0]          in_first,
  output pli_ctl_t                                     out_ctl,
  output logic signed [DATA_WIDTH-1:0]                 out_x,
  output logic signed [DATA_WIDTH-1:0]                 out_y,
  output logic [$clog2(MAX_KNOTS)-1:0]                 out_slot,
  output logic signed [DATA_WIDTH-1:0]                 out_xl,
  output logic signed [DATA_WIDTH-1:0]                 out_xr,
  output logic signed [DATA_WIDTH-1:0]                 out_yl,
  output logic signed [DATA_WIDTH-1:0]                 out_yr
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int NW = $clog2(MAX_KNOTS + 1);

  logic signed [DATA_WIDTH-1:0] abs_mem [MAX_KNOTS];
  logic signed [DATA_WIDTH-1:0] ord_mem [MAX_KNOTS];

  logic [NW-1:0] idx;
  logic [NW-1:0] idx_r;
  logic [AW-1:0] addr_l;
  logic [AW-1:0] addr_r;

  // left knot is one below the upper bound, kept off the last knot
  always_comb begin
    idx = (in_first == '0) ? '0 : in_first - NW'(1);
    if (idx + NW'(1) >= knots) begin
      idx = knots - NW'(2);
    end
    idx_r  = idx + NW'(1);
    addr_l = idx[AW-1:0];
    addr_r = idx_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= in_x;
      out_y    <= in_y;
      out_slot <= in_slot;
      out_xl   <= abs_mem[addr_l];
      out_xr   <= abs_mem[addr_r];
      out_yl   <= ord_mem[addr_l];
      out_yr   <= ord_mem[addr_r];
      if (in_ctl.valid && !in_ctl.query && in_ctl.slot_ok) begin
        abs_mem[in_slot] <= in_x;
        ord_mem[in_slot] <= in_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pli_end_read.sv
// reads the last knot in use, alongside the segment fetch
`timescale 1ns / 1ps
`default_nettype none

module pli_end_read
  import pli_pkg::*;
#(
  parameter int MAX_KNOTS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    en,
  input  wire logic [$clog2(MAX_KNOTS+1)-1:0]          knots,
  input  wire pli_ctl_t                                in_ctl,
  input  wire logic signed [DATA_WIDTH-1:0]            in_x,
  input  wire logic signed [DATA_WIDTH-1:0]            in_y,
  input  wire logic [$clog2(MAX_KNOTS)-1:0]            in_slot,
  output logic signed [DATA_WIDTH-1:0]                 end_x,
  output logic signed [DATA_WIDTH-1:0]                 end_y
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int NW = $clog2(MAX_KNOTS + 1);

  logic signed [DATA_WIDTH-1:0] abs_mem [MAX_KNOTS];
  logic signed [DATA_WIDTH-1:0] ord_mem [MAX_KNOTS];

  logic [NW-1:0] last;
  logic [AW-1:0] rd_addr;

  assign last    = knots - NW'(1);
  assign rd_addr = last[AW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      end_x <= abs_mem[rd_addr];
      end_y <= ord_mem[rd_addr];
      if (in_ctl.valid && !in_ctl.query && in_ctl.slot_ok) begin
        abs_mem[in_slot] <= in_x;
        ord_mem[in_slot] <= in_y;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/pli_divider.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
`default_nettype none

module pli_divider
  import pli_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int SIDE_WIDTH = 66
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [2*DATA_WIDTH-1:0]     in_num,
  input  wire logic [DATA_WIDTH-1:0]       in_den,
  input  wire logic [SIDE_WIDTH-1:0]       in_side,
  output logic                             out_valid,
  output logic [DATA_WIDTH:0]              out_quo,
  output logic                             out_sat,
  output logic [SIDE_WIDTH-1:0]            out_side
);

  // quotient bits kept; anything larger saturates the result anyway
  localparam int QW = DATA_WIDTH + 1;

  logic                  vld  [QW+1];
  logic [DATA_WIDTH-1:0] rem  [QW+1];
  logic [QW-1:0]         low  [QW+1];
  logic [QW-1:0]         quo  [QW+1];
  logic [DATA_WIDTH-1:0] den  [QW+1];
  logic                  sat  [QW+1];
  logic [SIDE_WIDTH-1:0] side [QW+1];

  logic [DATA_WIDTH-1:0] top_part;

  assign top_part = DATA_WIDTH'(in_num[2*DATA_WIDTH-1:QW]);

  // entry stage: high part of the dividend decides overflow
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= top_part;
      low[0]  <= in_num[QW-1:0];
      quo[0]  <= '0;
      den[0]  <= in_den;
      sat[0]  <= top_part >= in_den;
      side[0] <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_bit
    logic [DATA_WIDTH:0] trial;
    logic                fits;

    assign trial = {rem[i], low[i][QW-1]};
    assign fits  = trial >= {1'b0, den[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= fits ? DATA_WIDTH'(trial - {1'b0, den[i]}) : DATA_WIDTH'(trial);
        low[i+1]  <= low[i] << 1;
        quo[i+1]  <= {quo[i][QW-2:0], fits};
        den[i+1]  <= den[i];
        sat[i+1]  <= sat[i];
        side[i+1] <= side[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_sat   = sat[QW];
  assign out_side  = side[QW];

endmodule

`default_nettype wire

FILE: sv/pli_checker.sv
// port-level checks for the interpolator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module pli_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          kind,
  input wire logic [5:0]                    entry_index,
  input wire logic signed [DATA_WIDTH-1:0]  knot_x,
  input wire logic signed [DATA_WIDTH-1:0]  knot_y,
  input wire logic signed [DATA_WIDTH-1:0]  query_x,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [DATA_WIDTH-1:0]  value,
  input wire logic                          cfg_wr_en,
  input wire logic [6:0]                    cfg_wr_data
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a free output never stalls the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(value)))
    else $error("result beat changed while stalled");

endmodule

bind piecewise_linear_interpolator_unit pli_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_pli_checker (.*);

`default_nettype wire

FILE: tb/sv/piecewise_linear_interpolator_unit_tb.sv
// testbench for the piecewise linear interpolator: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module piecewise_linear_interpolator_unit_tb;
  import pli_pkg::*;

  localparam int KNOTS    = 64;
  localparam int DRAIN    = 70;  // beyond the pipeline depth, covers loads still in flight
  localparam int HOLD_LEN = 400; // long receiver hold-off, fills the pipeline

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum int {ROW_LOAD, ROW_QUERY, ROW_CFG} row_op_e;

  // one directed stimulus row; exp_known marks a result readable at a glance
  typedef struct {
    row_op_e              op;
    logic [5:0]           slot;
    logic signed [31:0]   kx;
    logic signed [31:0]   ky;
    logic signed [31:0]   qx;
    bit                   exp_known;
    logic signed [31:0]   exp_val;
  } dir_row_t;

  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KIND_LOAD;
  logic [5:0] entry_index = '0;
  logic signed [31:0] knot_x = '0;
  logic signed [31:0] knot_y = '0;
  logic signed [31:0] query_x = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] value;
  logic cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;

  // predictor state: knot table copy and count in use
  longint knot_abs[KNOTS];
  longint knot_ord[KNOTS];
  int     knots_active;

  logic signed [31:0] pending_values[$];
  int  error_count = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  pressure_req = 1'b0;
  bit  pressure_done = 1'b0;
  int  hold_left = 0;

  always #6 clk = ~clk;

  piecewise_linear_interpolator_unit #(.MAX_KNOTS(64), .DATA_WIDTH(32)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .entry_index(entry_index),
    .knot_x(knot_x), .knot_y(knot_y), .query_x(query_x),
    .out_valid(out_valid), .out_stall(out_stall), .value(value),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // interpolated value at x, upper-bound search over the active knots
  function automatic logic signed [31:0] interp_value(longint x);
    longint n, first, count, step, idx, xl, xr, yl, yr, w, r;
    longint unsigned a, d, qm;
    bit neg;
    n = (knots_active > KNOTS) ? KNOTS : knots_active;
    if (n == 0) return '0;
    if (n == 1) return knot_ord[0][31:0];
    if (x <= knot_abs[0]) return knot_ord[0][31:0];
    if (x >= knot_abs[n-1]) return knot_ord[n-1][31:0];
    first = 0;
    count = n;
    while (count > 0) begin
      step = count / 2;
      if (!(x < knot_abs[first+step])) begin
        first += step + 1;
        count -= step + 1;
      end else begin
        count = step;
      end
    end
    idx = (first == 0) ? 0 : first - 1;
    if (idx + 1 >= n) idx = n - 2;
    xl = knot_abs[idx];
    xr = knot_abs[idx+1];
    yl = knot_ord[idx];
    yr = knot_ord[idx+1];
    w = xr - xl;
    if (w <= 0) return yl[31:0];
    a = (x >= xl) ? longint'(x - xl) : 0;
    neg = yr < yl;
    d = neg ? longint'(yl - yr) : longint'(yr - yl);
    qm = (a * d) / longint'(w);
    if (qm > (64'd1 << 40)) qm = 64'd1 << 40;
    r = neg ? yl - longint'(qm) : yl + longint'(qm);
    // saturate to the signed 32-bit range when abscissae are out of order
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // offer one beat, hold it until accepted; the table copy and the expected
  // result are updated at the edge that takes the beat
  task automatic send_beat(input logic k, input logic [5:0] slot, input logic signed [31:0] kx,
                           input logic signed [31:0] ky, input logic signed [31:0] qx,
                           input bit known, input logic signed [31:0] known_val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    entry_index <= slot;
    knot_x      <= kx;
    knot_y      <= ky;
    query_x     <= qx;
    do @(posedge clk); while (in_stall);
    if (k == KIND_LOAD) begin
      knot_abs[slot] = kx;
      knot_ord[slot] = ky;
    end else begin
      pending_values.insert(pending_values.size(), known ? known_val : interp_value(qx));
    end
  endtask

  // wait for the pipeline to empty, then write the knot count
  task automatic write_knot_count(input logic [6:0] cnt);
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cnt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    knots_active = cnt;
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom;
  endfunction

  // query abscissa: mostly inside a segment, some knots hit exactly, some at the extremes, some anywhere
  function automatic logic signed [31:0] pick_query(int n);
    int sel, i;
    longint lo, hi, span, pick;
    sel = $urandom_range(99);
    if (n < 2 || sel < 15) return rand_word();
    if (sel < 20) return ($urandom_range(1)) ? S_MIN : S_MAX;
    i = $urandom_range(n - 2);
    if (sel < 30) return knot_abs[i][31:0];
    lo = knot_abs[i];
    hi = knot_abs[i+1];
    if (hi <= lo) return lo[31:0];
    span = hi - lo + 1;
    pick = lo + longint'({$urandom, $urandom} % longint'(span));
    return pick[31:0];
  endfunction

  // one random phase: load the knots in use, set the count, then queries mixed with reloads
  task automatic run_phase(input logic [6:0] cnt, input int queries);
    int eff, i, shape;
    logic signed [31:0] xs[];
    logic signed [31:0] base;
    eff = (cnt > KNOTS) ? KNOTS : cnt;
    shape = $urandom_range(9);
    xs = new[eff];
    base = rand_word();
    for (i = 0; i < eff; i++) begin
      if (shape < 5) xs[i] = rand_word();
      else xs[i] = (i == 0) ? (base >>> 2) : xs[i-1] + $urandom_range(1000);
    end
    if (shape < 4) xs.sort(); // shape 4 keeps wide abscissae out of order
    for (i = 0; i < eff; i++)
      send_beat(KIND_LOAD, i[5:0], xs[i],
                ($urandom_range(3) == 0) ? rand_word() : $signed($urandom_range(4000)) - 2000,
                rand_word(), 1'b0, '0);
    // a few loads past the active count must not disturb results
    repeat ($urandom_range(3)) begin
      if (eff < KNOTS)
        send_beat(KIND_LOAD, 6'($urandom_range(KNOTS - 1, eff)), rand_word(), rand_word(),
                  rand_word(), 1'b0, '0);
    end
    write_knot_count(cnt);
    repeat (queries) begin
      if ($urandom_range(19) == 0 && eff > 0)
        send_beat(KIND_LOAD, 6'($urandom_range(eff - 1)), rand_word(), rand_word(),
                  rand_word(), 1'b0, '0);
      else
        send_beat(KIND_QUERY, 6'($urandom), rand_word(), rand_word(), pick_query(eff),
                  1'b0, '0);
    end
  endtask

  // directed rows: empty table, single knot, both clamps, interior, duplicate abscissa, extremes
  dir_row_t dir_rows[21] = '{
    '{ROW_QUERY, 6'd0,  0,     0,     5,      1'b1, 0},
    '{ROW_LOAD,  6'd0,  -100,  7,     0,      1'b0, 0},
    '{ROW_LOAD,  6'd1,  100,   -7,    0,      1'b0, 0},
    '{ROW_CFG,   6'd1,  0,     0,     0,      1'b0, 0},
    '{ROW_QUERY, 6'd0,  0,     0,     12345,  1'b1, 7},
    '{ROW_CFG,   6'd2,  0,     0,     0,      1'b0, 0},
    '{ROW_QUERY, 6'd0,  0,     0,     -100,   1'b1, 7},
    '{ROW_QUERY, 6'd0,  0,     0,     S_MIN,  1'b1, 7},
    '{ROW_QUERY, 6'd0,  0,     0,     100,    1'b1, -7},
    '{ROW_QUERY, 6'd0,  0,     0,     S_MAX,  1'b1, -7},
    '{ROW_QUERY, 6'd0,  0,     0,     0,      1'b0, 0},
    '{ROW_QUERY, 6'd0,  0,     0,     33,     1'b0, 0},
    '{ROW_LOAD,  6'd2,  100,   99,    0,      1'b0, 0},
    '{ROW_LOAD,  6'd63, 300,   5,     0,      1'b0, 0},
    '{ROW_CFG,   6'd3,  0,     0,     0,      1'b0, 0},
    '{ROW_QUERY, 6'd0,  0,     0,     100,    1'b1, 99},
    '{ROW_LOAD,  6'd0,  S_MIN, S_MAX, 0,      1'b0, 0},
    '{ROW_LOAD,  6'd1,  S_MAX, S_MIN, 0,      1'b0, 0},
    '{ROW_CFG,   6'd2,  0,     0,     0,      1'b0, 0},
    '{ROW_QUERY, 6'd0,  0,     0,     0,      1'b0, 0},
    '{ROW_QUERY, 6'd0,  0,     0,     -1,     1'b0, 0}
  };

  // result side: stall at random, or hold off once for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_req && !pressure_done) begin
      out_stall     <= 1'b1;
      hold_left     <= HOLD_LEN;
      pressure_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // scoreboard: each accepted result against the oldest expected value
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_values.size() == 0) report_mismatch("unexpected beat", value, '0);
      else if (value !== pending_values[0]) report_mismatch("value", value, pending_values[0]);
      if (pending_values.size() != 0) void'(pending_values.pop_front());
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // knot counts per phase: extremes, small tables, above the table size
  logic [6:0] phase_counts[10] = '{7'd2, 7'd64, 7'd0, 7'd1, 7'd127, 7'd3, 7'd96, 7'd17, 7'd64, 7'd85};
  int idle_modes[4]  = '{0, 72, 0, 6};
  int stall_modes[4] = '{0, 0, 72, 6};

  initial begin
    int r, p;
    knots_active = 0;
    for (r = 0; r < KNOTS; r++) begin
      knot_abs[r] = 0;
      knot_ord[r] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      case (dir_rows[r].op)
        ROW_CFG: write_knot_count({1'b0, dir_rows[r].slot});
        ROW_LOAD: send_beat(KIND_LOAD, dir_rows[r].slot, dir_rows[r].kx, dir_rows[r].ky,
                            '0, 1'b0, '0);
        default: send_beat(KIND_QUERY, '0, '0, '0, dir_rows[r].qx,
                           dir_rows[r].exp_known, dir_rows[r].exp_val);
      endcase
    end

    for (p = 0; p < 10; p++) begin
      idle_pct  = idle_modes[p % 4];
      stall_pct = stall_modes[p % 4];
      // back-to-back offers while the receiver holds off
      if (p == 0) pressure_req = 1'b1;
      run_phase(phase_counts[p], 65);
    end
    in_valid <= 1'b0;

    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
